@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_PROP(lbl, !(cond), msg)

`endif

@@ rtl/vgatxt_pkg.sv @@
// Package for the VGA text register and cell attribute core.
// Holds the transaction kind codes and the register constants; no dependencies.
package vgatxt_pkg;

	typedef enum logic [2:0] {
		KIND_STATUS_RD = 3'd0,
		KIND_ATTR_WR   = 3'd1,
		KIND_ATTR_RD   = 3'd2,
		KIND_CRT_INDEX = 3'd3,
		KIND_CRT_WR    = 3'd4,
		KIND_CRT_RD    = 3'd5,
		KIND_BLINK     = 3'd6,
		KIND_CELL      = 3'd7
	} kind_t;

	localparam logic [7:0] MODE_RESET       = 8'h28;
	localparam int         MODE_ENABLE_BIT  = 5;
	localparam int         MODE_BLINK_BIT   = 3;
	localparam logic [7:0] BLANK_CHAR       = 8'h20;
	localparam logic [4:0] ATTR_MODE_INDEX  = 5'h10;
	localparam logic [7:0] CRT_CURSOR_START = 8'h0A;
	localparam logic [7:0] CRT_CURSOR_HI    = 8'h0E;
	localparam logic [7:0] CRT_CURSOR_LO    = 8'h0F;

endpackage

@@ rtl/vga_text_register_and_cell_attr_core.sv @@
// VGA text register block: attribute and CRT port registers, blink phase and cell decode.
// Depends on vgatxt_pkg and assert_macros.svh.
//
// channel  direction  handshake            payload
// in       to core    in_valid / in_ready  kind, data, cell_word, cell_pos
// out      from core  out_valid / out_ready read_data, glyph, fore_index, back_index,
//                                          blanked, cursor_here
//
// One transaction per cycle while the output is not stalled; a result passes the input
// register, then the result register, before it is offered.
// Register state changes when a transaction leaves the input register.
// arst_n clears all control state; the mode register resets to 0x28.
// A stalled output holds the result register; the input register still takes one more if it is empty.
`include "assert_macros.svh"

module vga_text_register_and_cell_attr_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  data,
	input  logic [15:0] cell_word,
	input  logic [15:0] cell_pos,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [7:0]  glyph,
	output logic [3:0]  fore_index,
	output logic [3:0]  back_index,
	output logic        blanked,
	output logic        cursor_here
);
	import vgatxt_pkg::*;

	logic        valid_s1;
	kind_t       kind_s1;
	logic [7:0]  data_s1;
	logic [15:0] cell_word_s1;
	logic [15:0] cell_pos_s1;

	logic        flip_armed_q;
	logic [4:0]  attr_index_q;
	logic        enable_pending_q;
	logic [7:0]  mode_q;
	logic [7:0]  crt_index_q;
	logic [15:0] cursor_pos_q;
	logic        blink_visible_q;

	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic [7:0]  glyph_q;
	logic [3:0]  fg_q;
	logic [3:0]  bg_q;
	logic        blanked_q;
	logic        cursor_q;

	logic        advance;
	logic        fire;

	logic        flip_armed_d;
	logic [4:0]  attr_index_d;
	logic        enable_pending_d;
	logic [7:0]  mode_d;
	logic [7:0]  crt_index_d;
	logic [15:0] cursor_pos_d;
	logic        blink_visible_d;

	logic [7:0]  rd_d;
	logic [7:0]  glyph_d;
	logic [3:0]  fg_d;
	logic [3:0]  bg_d;
	logic        blanked_d;
	logic        cursor_d;

	logic [3:0]  bgi;
	logic        blink_mode;
	logic        enable_in;

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1      <= kind_t'(kind);
			data_s1      <= data;
			cell_word_s1 <= cell_word;
			cell_pos_s1  <= cell_pos;
		end
	end

	assign bgi        = cell_word_s1[15:12];
	assign blink_mode = mode_q[MODE_BLINK_BIT];
	assign enable_in  = data_s1[MODE_ENABLE_BIT];

	always_comb begin
		flip_armed_d     = flip_armed_q;
		attr_index_d     = attr_index_q;
		enable_pending_d = enable_pending_q;
		mode_d           = mode_q;
		crt_index_d      = crt_index_q;
		cursor_pos_d     = cursor_pos_q;
		blink_visible_d  = blink_visible_q;
		rd_d             = 8'd0;
		glyph_d          = 8'd0;
		fg_d             = 4'd0;
		bg_d             = 4'd0;
		blanked_d        = 1'b0;
		cursor_d         = 1'b0;
		unique case (kind_s1)
			KIND_STATUS_RD: begin
				flip_armed_d = 1'b1;
			end
			KIND_ATTR_WR: begin
				if (flip_armed_q) begin
					attr_index_d  = data_s1[4:0];
					flip_armed_d  = 1'b0;
					if (enable_in) begin
						enable_pending_d = 1'b1;
					end
				end else if (attr_index_q[4]) begin
					mode_d                  = data_s1;
					mode_d[MODE_ENABLE_BIT] = enable_pending_q || enable_in;
					enable_pending_d        = 1'b0;
					attr_index_d            = 5'd0;
				end
			end
			KIND_ATTR_RD: begin
				if (!flip_armed_q && attr_index_q == ATTR_MODE_INDEX) begin
					attr_index_d = 5'd0;
					rd_d         = mode_q;
				end else begin
					flip_armed_d     = 1'b0;
					enable_pending_d = 1'b0;
				end
			end
			KIND_CRT_INDEX: begin
				crt_index_d = data_s1;
			end
			KIND_CRT_WR: begin
				if (crt_index_q == CRT_CURSOR_HI) begin
					cursor_pos_d[15:8] = data_s1;
				end else if (crt_index_q == CRT_CURSOR_LO) begin
					cursor_pos_d[7:0] = data_s1;
				end
			end
			KIND_CRT_RD: begin
				if (crt_index_q == CRT_CURSOR_START || crt_index_q == CRT_CURSOR_HI) begin
					rd_d = cursor_pos_q[15:8];
				end else if (crt_index_q == CRT_CURSOR_LO) begin
					rd_d = cursor_pos_q[7:0];
				end
			end
			KIND_BLINK: begin
				blink_visible_d = !blink_visible_q;
			end
			KIND_CELL: begin
				if (!mode_q[MODE_ENABLE_BIT]) begin
					glyph_d   = BLANK_CHAR;
					blanked_d = 1'b1;
				end else begin
					cursor_d = (cell_pos_s1 == cursor_pos_q) && blink_visible_q;
					if (blink_mode && bgi[3] && !blink_visible_q) begin
						glyph_d   = BLANK_CHAR;
						blanked_d = 1'b1;
					end else begin
						glyph_d = cell_word_s1[7:0];
						fg_d    = cell_word_s1[11:8];
						bg_d    = blink_mode ? {1'b0, bgi[2:0]} : bgi;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_armed_q     <= 1'b0;
			attr_index_q     <= 5'd0;
			enable_pending_q <= 1'b0;
			mode_q           <= MODE_RESET;
			crt_index_q      <= 8'd0;
			cursor_pos_q     <= 16'd0;
			blink_visible_q  <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (fire) begin
				flip_armed_q     <= flip_armed_d;
				attr_index_q     <= attr_index_d;
				enable_pending_q <= enable_pending_d;
				mode_q           <= mode_d;
				crt_index_q      <= crt_index_d;
				cursor_pos_q     <= cursor_pos_d;
				blink_visible_q  <= blink_visible_d;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q <= rd_d;
			glyph_q     <= glyph_d;
			fg_q        <= fg_d;
			bg_q        <= bg_d;
			blanked_q   <= blanked_d;
			cursor_q    <= cursor_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign glyph       = glyph_q;
	assign fore_index  = fg_q;
	assign back_index  = bg_q;
	assign blanked     = blanked_q;
	assign cursor_here = cursor_q;

	`ASSERT_PROP(a_blank_clears,
		out_valid && blanked |->
			glyph == BLANK_CHAR && fore_index == 4'd0 && back_index == 4'd0,
		"blanked cell carries color or glyph")
	`ASSERT_NEVER(a_cursor_blank, out_valid && cursor_here && blanked,
		"cursor flagged on a blanked cell")
	`ASSERT_PROP(a_read_no_cell,
		out_valid && read_data != 8'd0 |-> glyph == 8'd0 && !blanked && !cursor_here,
		"port read result carries cell fields")
	`ASSERT_PROP(a_ready_stall, !in_ready |-> valid_s1 && out_valid && !out_ready,
		"input held off without an output stall")

endmodule
